// File: rtl/clkpr_pkg.sv
// shared constants, types and register codes for the clock page replacement unit
// no dependencies; used by clkpr_seq, the top level and the testbench
`default_nettype none

package clkpr_pkg;

    localparam int MAX_FRAMES_DEF = 64;
    // frame_index and the clock hand are 6 bits wide, so no more frames than this are addressable
    localparam int FRAMES_CAP     = 64;

    localparam int ADDR_W         = 32;
    localparam int OFFS_BITS_W    = 5;
    localparam int FRAMES_W       = 7;
    localparam int CFG_DATA_W     = 7;
    localparam int CFG_IDX_W      = 1;
    localparam int FRAME_OUT_W    = 6;
    localparam int HAND_W         = 6;
    localparam int PHYS_W         = 37;
    localparam int OFFSET_W       = 31;
    localparam int COUNT_W        = 32;
    localparam int CMP_W          = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_PAGE_OFFSET_BITS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAMES_IN_USE    = 1'd1;

    localparam logic [OFFS_BITS_W-1:0] PAGE_OFFSET_BITS_RST = 5'd12;
    localparam logic [FRAMES_W-1:0]    FRAMES_IN_USE_RST    = 7'd64;

    // top level to sequencer
    typedef struct packed {
        logic              start;
        logic              out_free;
        logic [ADDR_W-1:0] page;
        logic [FRAMES_W-1:0] last;
    } seq_req_t;

    // sequencer to top level
    typedef struct packed {
        logic                idle;
        logic                done;
        logic                hit;
        logic [FRAMES_W-1:0] frame;
    } seq_rsp_t;

endpackage

`default_nettype wire

// File: rtl/clkpr_if.sv
// valid/ready channel interfaces for address transactions and result transactions
// depends on nothing but the field widths written out here
`default_nettype none

interface clkpr_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] virtual_address;

    modport source (output valid, output virtual_address, input ready);
    modport sink   (input valid, input virtual_address, output ready);
endinterface

interface clkpr_out_if;
    logic        valid;
    logic        ready;
    logic        hit;
    logic [5:0]  frame_index;
    logic [36:0] physical_address;
    logic [31:0] virtual_page;
    logic [30:0] page_offset;
    logic [31:0] reference_count;
    logic [31:0] fault_count;

    modport source (output valid, output hit, output frame_index, output physical_address,
                    output virtual_page, output page_offset, output reference_count,
                    output fault_count, input ready);
    modport sink   (input valid, input hit, input frame_index, input physical_address,
                    input virtual_page, input page_offset, input reference_count,
                    input fault_count, output ready);
endinterface

`default_nettype wire

// File: rtl/clkpr_tag_mem.sv
// page tag store: one write port, one read port with registered read data
// depends on nothing; instantiated by clkpr_seq
`default_nettype none

module clkpr_tag_mem #(
    parameter int DEPTH = 64,
    parameter int IW    = 6,
    parameter int TW    = 32
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [IW-1:0] waddr,
    input  wire logic [TW-1:0] wdata,
    input  wire logic [IW-1:0] raddr,
    output logic      [TW-1:0] rdata
);

    logic [TW-1:0] tag_mem_reg [DEPTH];
    logic [TW-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            tag_mem_reg[waddr] <= wdata;
        end
        rdata_reg <= tag_mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: rtl/clkpr_seq.sv
// sequencer: one tag compare per cycle over the frames, then a clock sweep over the use bits
// when a miss finds every active frame full; depends on clkpr_pkg and clkpr_tag_mem
`default_nettype none

module clkpr_seq #(
    parameter int DEPTH = 64
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire clkpr_pkg::seq_req_t req,
    output clkpr_pkg::seq_rsp_t    rsp
);

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_LOOK    = 3'd1;
    localparam logic [2:0] S_SWEEP   = 3'd2;
    localparam logic [2:0] S_INSTALL = 3'd3;
    localparam logic [2:0] S_DONE    = 3'd4;

    logic [2:0]                     state_reg, state_next;
    logic [IW-1:0]                  idx_reg, idx_next;
    logic [IW-1:0]                  frame_reg, frame_next;
    logic                           hit_reg, hit_next;
    logic                           empty_reg, empty_next;
    logic [IW-1:0]                  empty_idx_reg, empty_idx_next;
    logic [clkpr_pkg::HAND_W-1:0]   hand_reg, hand_next;
    logic [DEPTH-1:0]               valid_reg, valid_next;
    logic [DEPTH-1:0]               use_reg, use_next;

    logic [IW-1:0]                  last;
    logic [IW-1:0]                  idx_wrap;
    logic [IW-1:0]                  hand_start;
    logic                           match;
    logic [clkpr_pkg::ADDR_W-1:0]   rd_tag;
    logic                           mem_we;

    assign last     = IW'(req.last);
    assign idx_wrap = (idx_reg == last) ? '0 : IW'(idx_reg + 1'b1);
    // a hand past the active frames restarts at frame zero
    assign hand_start = (clkpr_pkg::CMP_W'(hand_reg) > clkpr_pkg::CMP_W'(req.last))
                        ? '0 : IW'(hand_reg);
    assign match    = valid_reg[idx_reg] && (rd_tag == req.page);
    assign mem_we   = (state_reg == S_INSTALL);

    clkpr_tag_mem #(
        .DEPTH (DEPTH),
        .IW    (IW),
        .TW    (clkpr_pkg::ADDR_W)
    ) u_tag_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (frame_reg),
        .wdata (req.page),
        .raddr (idx_next),
        .rdata (rd_tag)
    );

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        frame_next     = frame_reg;
        hit_next       = hit_reg;
        empty_next     = empty_reg;
        empty_idx_next = empty_idx_reg;
        hand_next      = hand_reg;
        valid_next     = valid_reg;
        use_next       = use_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req.start)
                begin
                    idx_next   = '0;
                    empty_next = 1'b0;
                    hit_next   = 1'b0;
                    state_next = S_LOOK;
                end
            end
            S_LOOK:
            begin
                if (match)
                begin
                    hit_next          = 1'b1;
                    frame_next        = idx_reg;
                    use_next[idx_reg] = 1'b1;
                    state_next        = S_DONE;
                end
                else if (idx_reg == last)
                begin
                    if (empty_reg)
                    begin
                        frame_next = empty_idx_reg;
                        state_next = S_INSTALL;
                    end
                    else if (!valid_reg[idx_reg])
                    begin
                        frame_next = idx_reg;
                        state_next = S_INSTALL;
                    end
                    else
                    begin
                        idx_next   = hand_start;
                        state_next = S_SWEEP;
                    end
                end
                else
                begin
                    // remember the lowest empty frame seen so far
                    if (!valid_reg[idx_reg] && !empty_reg)
                    begin
                        empty_next     = 1'b1;
                        empty_idx_next = idx_reg;
                    end
                    idx_next = IW'(idx_reg + 1'b1);
                end
            end
            S_SWEEP:
            begin
                if (use_reg[idx_reg])
                begin
                    use_next[idx_reg] = 1'b0;
                    idx_next          = idx_wrap;
                end
                else
                begin
                    frame_next = idx_reg;
                    hand_next  = clkpr_pkg::HAND_W'(idx_wrap);
                    state_next = S_INSTALL;
                end
            end
            S_INSTALL:
            begin
                valid_next[frame_reg] = 1'b1;
                use_next[frame_reg]   = 1'b1;
                state_next            = S_DONE;
            end
            S_DONE:
            begin
                if (req.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            hand_reg  <= '0;
            valid_reg <= '0;
            use_reg   <= '0;
            hit_reg   <= 1'b0;
            empty_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            hand_reg  <= hand_next;
            valid_reg <= valid_next;
            use_reg   <= use_next;
            hit_reg   <= hit_next;
            empty_reg <= empty_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg       <= idx_next;
        frame_reg     <= frame_next;
        empty_idx_reg <= empty_idx_next;
    end

    assign rsp.idle  = (state_reg == S_IDLE);
    assign rsp.done  = (state_reg == S_DONE);
    assign rsp.hit   = hit_reg;
    assign rsp.frame = clkpr_pkg::FRAMES_W'(frame_reg);

endmodule

`default_nettype wire

// File: rtl/clock_page_replacement_mmu_unit.sv
// a hit ends the tag search at the matching frame; a miss with an empty frame searches all active
// frames and installs in the lowest empty one; a miss with all frames full adds the clock sweep; the
// search is the single tag compare stepping through the tag memory
// throughput: one transaction in flight; the next address is taken once the result is stored
// reset: frames empty, use bits and clock hand zero, counters zero, page size 4 KiB, 64 frames
// top level: config registers, address split, counters and the result register
`default_nettype none

module clock_page_replacement_mmu_unit #(
    parameter int MAX_FRAMES = clkpr_pkg::MAX_FRAMES_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    clkpr_in_if.sink                              trace,
    clkpr_out_if.source                           result,
    input  wire logic                             cfg_we,
    input  wire logic [clkpr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [clkpr_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int DEPTH = (MAX_FRAMES < clkpr_pkg::FRAMES_CAP) ? MAX_FRAMES
                                                                : clkpr_pkg::FRAMES_CAP;

    logic [clkpr_pkg::OFFS_BITS_W-1:0] offs_bits_reg;
    logic [clkpr_pkg::FRAMES_W-1:0]    frames_reg;
    logic [clkpr_pkg::FRAMES_W-1:0]    last;
    logic [clkpr_pkg::ADDR_W-1:0]      page_reg;
    logic [clkpr_pkg::OFFSET_W-1:0]    offset_reg;
    logic [clkpr_pkg::ADDR_W-1:0]      offs_mask;
    logic [clkpr_pkg::COUNT_W-1:0]     refs_reg;
    logic [clkpr_pkg::COUNT_W-1:0]     faults_reg;
    logic [clkpr_pkg::COUNT_W-1:0]     faults_next;
    logic                              out_valid_reg;
    logic                              out_free;
    logic                              accept;
    logic                              load;
    logic [clkpr_pkg::FRAME_OUT_W-1:0] frame_out;

    clkpr_pkg::seq_req_t req;
    clkpr_pkg::seq_rsp_t rsp;

    // active frame count clamped to 1..DEPTH, carried as the last frame index
    always_comb
    begin
        if (frames_reg == '0)
        begin
            last = '0;
        end
        else if (frames_reg > clkpr_pkg::FRAMES_W'(DEPTH))
        begin
            last = clkpr_pkg::FRAMES_W'(DEPTH - 1);
        end
        else
        begin
            last = frames_reg - 1'b1;
        end
    end

    assign accept      = trace.valid && trace.ready;
    assign out_free    = !out_valid_reg || result.ready;
    assign load        = rsp.done && out_free;
    assign offs_mask   = ~({clkpr_pkg::ADDR_W{1'b1}} << offs_bits_reg);
    assign faults_next = rsp.hit ? faults_reg : faults_reg + 1'b1;
    assign frame_out   = clkpr_pkg::FRAME_OUT_W'(rsp.frame);

    assign req.start    = accept;
    assign req.out_free = out_free;
    assign req.page     = page_reg;
    assign req.last     = last;

    assign trace.ready = rsp.idle;

    clkpr_seq #(
        .DEPTH (DEPTH)
    ) u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offs_bits_reg <= clkpr_pkg::PAGE_OFFSET_BITS_RST;
            frames_reg    <= clkpr_pkg::FRAMES_IN_USE_RST;
            refs_reg      <= '0;
            faults_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    clkpr_pkg::CFG_PAGE_OFFSET_BITS:
                    begin
                        offs_bits_reg <= cfg_data[clkpr_pkg::OFFS_BITS_W-1:0];
                    end
                    clkpr_pkg::CFG_FRAMES_IN_USE:
                    begin
                        frames_reg <= cfg_data;
                    end
                    default:
                    begin
                        frames_reg <= frames_reg;
                    end
                endcase
            end
            if (accept)
            begin
                refs_reg <= refs_reg + 1'b1;
            end
            if (load)
            begin
                faults_reg    <= faults_next;
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            page_reg   <= trace.virtual_address >> offs_bits_reg;
            offset_reg <= clkpr_pkg::OFFSET_W'(trace.virtual_address & offs_mask);
        end
        if (load)
        begin
            result.hit              <= rsp.hit;
            result.frame_index      <= frame_out;
            result.physical_address <= (clkpr_pkg::PHYS_W'(frame_out) << offs_bits_reg)
                                       | clkpr_pkg::PHYS_W'(offset_reg);
            result.virtual_page     <= page_reg;
            result.page_offset      <= offset_reg;
            result.reference_count  <= refs_reg;
            result.fault_count      <= faults_next;
        end
    end

    assign result.valid = out_valid_reg;

`ifndef ASSERT_OFF
    // a result frame always lies within the active frames
    a_frame_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> (rsp.frame <= last))
        else $error("result frame outside the active frames");

    // the sequencer is busy in the cycle after it accepts a transaction
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !trace.ready)
        else $error("address taken while a lookup is running");

    // a finished lookup is not overrun by a new address
    a_done_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.done |-> !trace.ready)
        else $error("input ready while a result is pending in the sequencer");
`endif

endmodule

`default_nettype wire

// File: sim/clock_page_replacement_mmu_unit_test.sv
`timescale 1ns / 100ps
// self-checking testbench for clock_page_replacement_mmu_unit: directed stimulus table, then
// random address traces over several page-size and frame-count settings
// depends on rtl/clkpr_pkg.sv, rtl/clkpr_if.sv and the block itself

module clock_page_replacement_mmu_unit_test;
    import clkpr_pkg::*;

    localparam int FRAME_SLOTS     = 64;
    localparam int IDLE_LIMIT      = 4000;
    localparam int DRAIN_CYCLES    = 3 * FRAME_SLOTS + 10;
    localparam int LONG_HOLD       = 400;
    localparam int NUM_PHASES      = 12;
    localparam int ITEMS_PER_PHASE = 167;
    localparam int PHASE_OFFS   [NUM_PHASES] = '{0, 31, 12, 4, 20, 30, 1, 16, 8, 12, 2, 24};
    localparam int PHASE_FRAMES [NUM_PHASES] = '{1, 2, 4, 64, 8, 0, 3, 127, 16, 5, 64, 7};

    typedef struct packed {
        logic                  hit;
        logic [FRAME_OUT_W-1:0] frame;
        logic [PHYS_W-1:0]     phys;
        logic [ADDR_W-1:0]     vpage;
        logic [OFFSET_W-1:0]   offs;
        logic [COUNT_W-1:0]    refs;
        logic [COUNT_W-1:0]    faults;
    } mmu_result_t;

    typedef enum logic {STEP_ADDR, STEP_CFG} step_kind_e;

    typedef struct {
        step_kind_e             kind;
        logic [CFG_IDX_W-1:0]   reg_idx;
        logic [CFG_DATA_W-1:0]  reg_val;
        logic [ADDR_W-1:0]      addr;
        bit                     typed;
        logic                   hit;
        logic [FRAME_OUT_W-1:0] frame;
        logic [COUNT_W-1:0]     faults;
    } stim_row_t;

    localparam int NUM_ROWS = 21;
    stim_row_t directed_steps [NUM_ROWS] = '{
        // empty frames fill from the bottom, same page hits
        '{STEP_ADDR, CFG_PAGE_OFFSET_BITS, 7'd0, 32'h0000_0000, 1'b1, 1'b0, 6'd0, 32'd1},
        '{STEP_ADDR, CFG_PAGE_OFFSET_BITS, 7'd0, 32'h0000_0FFF, 1'b1, 1'b1, 6'd0, 32'd1},
        '{STEP_ADDR, CFG_PAGE_OFFSET_BITS, 7'd0, 32'hFFFF_FFFF, 1'b1, 1'b0, 6'd1, 32'd2},
        '{STEP_ADDR, CFG_PAGE_OFFSET_BITS, 7'd0, 32'hFFFF_F000, 1'b1, 1'b1, 6'd1, 32'd2},
        // two frames, full: the sweep clears both use bits and evicts frame 0
        '{STEP_CFG,  CFG_FRAMES_IN_USE,    7'd2, 32'h0,         1'b0, 1'b0, 6'd0, 32'd0},
        '{STEP_ADDR, CFG_PAGE_OFFSET_BITS, 7'd0, 32'h1234_5678, 1'b1, 1'b0, 6'd0, 32'd3},
        '{STEP_ADDR, CFG_PAGE_OFFSET_BITS, 7'd0, 32'h0000_0ABC, 1'b1, 1'b0, 6'd1, 32'd4},
        // upper data bits are dropped, so this is a page size of one byte
        '{STEP_CFG,  CFG_PAGE_OFFSET_BITS, 7'h60, 32'h0,        1'b0, 1'b0, 6'd0, 32'd0},
        '{STEP_ADDR, CFG_PAGE_OFFSET_BITS, 7'd0, 32'hFFFF_FFFF, 1'b1, 1'b0, 6'd0, 32'd5},
        '{STEP_ADDR, CFG_PAGE_OFFSET_BITS, 7'd0, 32'h0000_0000, 1'b1, 1'b1, 6'd1, 32'd5},
        '{STEP_CFG,  CFG_PAGE_OFFSET_BITS, 7'h1F, 32'h0,        1'b0, 1'b0, 6'd0, 32'd0},
        '{STEP_ADDR, CFG_PAGE_OFFSET_BITS, 7'd0, 32'h8000_0000, 1'b1, 1'b0, 6'd1, 32'd6},
        '{STEP_ADDR, CFG_PAGE_OFFSET_BITS, 7'd0, 32'h7FFF_FFFF, 1'b0, 1'b0, 6'd0, 32'd0},
        // frame count of zero acts as one, hand beyond the count restarts at 0
        '{STEP_CFG,  CFG_FRAMES_IN_USE,    7'd0, 32'h0,         1'b0, 1'b0, 6'd0, 32'd0},
        '{STEP_ADDR, CFG_PAGE_OFFSET_BITS, 7'd0, 32'hFFFF_FFFF, 1'b1, 1'b0, 6'd0, 32'd8},
        // count above the maximum acts as the maximum; page 1 now sits in frames 0 and 1
        '{STEP_CFG,  CFG_FRAMES_IN_USE,    7'h7F, 32'h0,        1'b0, 1'b0, 6'd0, 32'd0},
        '{STEP_ADDR, CFG_PAGE_OFFSET_BITS, 7'd0, 32'h8000_0001, 1'b1, 1'b1, 6'd0, 32'd8},
        '{STEP_ADDR, CFG_PAGE_OFFSET_BITS, 7'd0, 32'h0000_0000, 1'b1, 1'b0, 6'd2, 32'd9},
        '{STEP_CFG,  CFG_PAGE_OFFSET_BITS, 7'd12, 32'h0,        1'b0, 1'b0, 6'd0, 32'd0},
        '{STEP_ADDR, CFG_PAGE_OFFSET_BITS, 7'd0, 32'hAAAA_AAAA, 1'b0, 1'b0, 6'd0, 32'd0},
        '{STEP_ADDR, CFG_PAGE_OFFSET_BITS, 7'd0, 32'h5555_5555, 1'b0, 1'b0, 6'd0, 32'd0}
    };

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    clkpr_in_if  trace_ch ();
    clkpr_out_if result_ch ();

    clock_page_replacement_mmu_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .trace     (trace_ch),
        .result    (result_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #4 clk = ~clk;

    // translation state mirrored from the block
    logic [ADDR_W-1:0]      tag_mem   [FRAME_SLOTS];
    bit                     valid_mem [FRAME_SLOTS];
    bit                     use_mem   [FRAME_SLOTS];
    int unsigned            hand;
    logic [COUNT_W-1:0]     refs_total;
    logic [COUNT_W-1:0]     faults_total;
    logic [OFFS_BITS_W-1:0] offs_bits_cfg;
    logic [FRAMES_W-1:0]    frames_cfg;

    mmu_result_t pending_results [$];
    int          errors;
    int          items_sent;
    int          results_checked;
    int          hits_seen;
    int          faults_seen;
    int          settings_used;
    int          burst_left;

    function automatic int unsigned active_frames();
        if (frames_cfg == 0)
            return 1;
        if (frames_cfg > FRAME_SLOTS)
            return FRAME_SLOTS;
        return frames_cfg;
    endfunction

    function automatic mmu_result_t translate_address(input logic [ADDR_W-1:0] addr);
        mmu_result_t       r;
        int unsigned       n;
        int unsigned       h;
        int unsigned       fr;
        bit                found;
        bit                placed;
        logic [ADDR_W-1:0] offs;
        logic [ADDR_W-1:0] vpn;
        n = active_frames();
        offs = addr & 32'((64'd1 << offs_bits_cfg) - 64'd1);
        vpn = addr >> offs_bits_cfg;
        refs_total = refs_total + 1;
        found = 0;
        placed = 0;
        fr = 0;
        for (int i = 0; i < n; i++)
        begin
            if (!found && valid_mem[i] && tag_mem[i] == vpn)
            begin
                fr = i;
                found = 1;
            end
        end
        if (found)
            use_mem[fr] = 1;
        else
        begin
            faults_total = faults_total + 1;
            for (int i = 0; i < n; i++)
            begin
                if (!placed && !valid_mem[i])
                begin
                    fr = i;
                    placed = 1;
                end
            end
            if (!placed)
            begin
                h = (hand >= n) ? 0 : hand;
                // first lap clears every use bit, so this stops within two laps
                while (use_mem[h])
                begin
                    use_mem[h] = 0;
                    h = (h + 1) % n;
                end
                fr = h;
                hand = (h + 1) % n;
            end
            valid_mem[fr] = 1;
            tag_mem[fr] = vpn;
            use_mem[fr] = 1;
        end
        r.hit = found;
        r.frame = fr[FRAME_OUT_W-1:0];
        r.phys = (PHYS_W'(fr) << offs_bits_cfg) | PHYS_W'(offs);
        r.vpage = vpn;
        r.offs = offs[OFFSET_W-1:0];
        r.refs = refs_total;
        r.faults = faults_total;
        return r;
    endfunction

    // called at a falling edge; returns at the falling edge after the transaction
    task automatic send_address(input logic [ADDR_W-1:0] addr, input bit typed = 0,
                                input logic t_hit = 0, input logic [FRAME_OUT_W-1:0] t_frame = 0,
                                input logic [COUNT_W-1:0] t_faults = 0);
        int          gap;
        mmu_result_t pred;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0)
            begin
                trace_ch.valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        trace_ch.valid <= 1'b1;
        trace_ch.virtual_address <= addr;
        @(posedge clk);
        while (!trace_ch.ready)
            @(posedge clk);
        pred = translate_address(addr);
        if (typed)
        begin
            pred.hit = t_hit;
            pred.frame = t_frame;
            pred.faults = t_faults;
        end
        pending_results.push_back(pred);
        items_sent++;
        burst_left--;
        @(negedge clk);
    endtask

    // called at a falling edge; only once every result is back
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] val);
        trace_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        if (idx == CFG_PAGE_OFFSET_BITS)
            offs_bits_cfg = val[OFFS_BITS_W-1:0];
        else
            frames_cfg = val;
        @(negedge clk);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got)
        begin
            errors++;
            $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    // result side: compare each transaction with the oldest prediction
    always @(posedge clk)
    begin
        mmu_result_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (pending_results.size() == 0)
            begin
                errors++;
                $display("%0t ns: unexpected result, expected nothing, actual frame %0d",
                         $time, result_ch.frame_index);
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("hit", want.hit, result_ch.hit);
                check_field("frame_index", want.frame, result_ch.frame_index);
                check_field("physical_address", want.phys, result_ch.physical_address);
                check_field("virtual_page", want.vpage, result_ch.virtual_page);
                check_field("page_offset", want.offs, result_ch.page_offset);
                check_field("reference_count", want.refs, result_ch.reference_count);
                check_field("fault_count", want.faults, result_ch.fault_count);
            end
            results_checked++;
            if (result_ch.hit)
                hits_seen++;
            else
                faults_seen++;
        end
    end

    // receiver stall pattern, with one long hold-off to back the block up
    int  rx_mode;
    int  rx_count;
    int  hold_left;
    bit  hold_done;

    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left--;
            result_ch.ready <= 1'b0;
        end
        else if (!hold_done && results_checked >= 300)
        begin
            hold_done = 1;
            hold_left = LONG_HOLD;
            result_ch.ready <= 1'b0;
        end
        else
        begin
            if (rx_count == 0)
            begin
                rx_mode = $urandom_range(0, 3);
                rx_count = $urandom_range(20, 80);
            end
            rx_count--;
            case (rx_mode)
                0:       result_ch.ready <= 1'b1;
                1:       result_ch.ready <= ($urandom_range(0, 3) != 0);
                2:       result_ch.ready <= ($urandom_range(0, 3) == 0);
                default: result_ch.ready <= rx_count[0];
            endcase
        end
    end

    int idle_cycles;

    always @(posedge clk)
    begin
        if ((trace_ch.valid && trace_ch.ready) || (result_ch.valid && result_ch.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("%0t ns: no transaction for %0d cycles", $time, IDLE_LIMIT);
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin
        int                unsigned n_eff;
        logic [ADDR_W-1:0] addr;
        logic [ADDR_W-1:0] off_mask;
        logic [ADDR_W-1:0] page_pool [$];

        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        trace_ch.valid = 1'b0;
        trace_ch.virtual_address = '0;
        result_ch.ready = 1'b0;
        for (int i = 0; i < FRAME_SLOTS; i++)
        begin
            tag_mem[i] = '0;
            valid_mem[i] = 0;
            use_mem[i] = 0;
        end
        hand = 0;
        refs_total = '0;
        faults_total = '0;
        offs_bits_cfg = PAGE_OFFSET_BITS_RST;
        frames_cfg = FRAMES_IN_USE_RST;
        errors = 0;
        items_sent = 0;
        results_checked = 0;
        hits_seen = 0;
        faults_seen = 0;
        settings_used = 1;
        burst_left = 0;
        rx_mode = 0;
        rx_count = 0;
        hold_left = 0;
        hold_done = 0;
        idle_cycles = 0;

        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_steps[s])
        begin
            if (directed_steps[s].kind == STEP_CFG)
                write_register(directed_steps[s].reg_idx, directed_steps[s].reg_val);
            else
                send_address(directed_steps[s].addr, directed_steps[s].typed,
                             directed_steps[s].hit, directed_steps[s].frame,
                             directed_steps[s].faults);
        end

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            write_register(CFG_PAGE_OFFSET_BITS,
                           {2'($urandom_range(0, 3)), 5'(PHASE_OFFS[p])});
            write_register(CFG_FRAMES_IN_USE, 7'(PHASE_FRAMES[p]));
            n_eff = active_frames();
            off_mask = 32'((64'd1 << offs_bits_cfg) - 64'd1);
            // working set a bit larger than the frames, so hits and evictions mix
            page_pool.delete();
            for (int i = 0; i < n_eff + n_eff / 2 + 1; i++)
                page_pool.push_back($urandom() >> offs_bits_cfg);
            for (int k = 0; k < ITEMS_PER_PHASE; k++)
            begin
                if ($urandom_range(0, 99) < 85)
                    addr = (page_pool[$urandom_range(0, page_pool.size() - 1)] << offs_bits_cfg)
                           | ($urandom() & off_mask);
                else
                    addr = $urandom();
                send_address(addr);
            end
        end

        trace_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("ran %0d addresses over %0d register settings: %0d hits, %0d page faults",
                 items_sent, settings_used, hits_seen, faults_seen);
        $display("%0d results checked, %0d mismatches", results_checked, errors);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// File: files.f
rtl/clkpr_pkg.sv
rtl/clkpr_if.sv
rtl/clkpr_tag_mem.sv
rtl/clkpr_seq.sv
rtl/clock_page_replacement_mmu_unit.sv
sim/clock_page_replacement_mmu_unit_test.sv
